/* hdl/fses_pkg.sv */
// Shared constants, register indexes and item types of the segment erase sequencer.
package fses_pkg;

  // Flash geometry.
  localparam int SEGMENT_BYTES = 32;
  localparam int SEGMENT_COUNT = 128;

  // Field widths fixed by the interface.
  localparam int AddrW = 32;
  localparam int LenW  = 16;
  localparam int SegW  = 7;
  localparam int PendW = 8;

  // Highest usable segment count: bounded by the flash and by the segment field.
  localparam int SegFieldLimit = 1 << SegW;
  localparam int SegLimit      = (SEGMENT_COUNT > SegFieldLimit) ? SegFieldLimit : SEGMENT_COUNT;

  // Configuration register indexes.
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_WIN_START = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_WIN_END   = 1'b1;

  // Reset values of the window registers.
  localparam logic [AddrW-1:0] WinStartReset = 32'd100352;
  localparam logic [AddrW-1:0] WinEndReset   = 32'd104447;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_POLL  = 1'b1
  } command_e;

  typedef struct packed {
    command_e               command;
    logic [AddrW-1:0]       target_address;
    logic [LenW-1:0]        length_bytes;
    logic                   flash_busy;
  } item_t;

  typedef struct packed {
    logic [PendW-1:0] pending_count;
    logic [SegW-1:0]  current_segment;
  } seq_state_t;

  typedef struct packed {
    logic             status;
    logic             erase_issue;
    logic [SegW-1:0]  erase_segment;
    logic [PendW-1:0] segments_left;
  } result_t;

endpackage

/* hdl/fses_step.sv */
// Next-state and result logic for one start or poll item of the erase sequencer.
module fses_step import fses_pkg::*; (
  input  item_t            item_i,
  input  seq_state_t       state_i,
  input  logic [AddrW-1:0] win_start_i,
  input  logic [AddrW-1:0] win_end_i,
  output seq_state_t       state_o,
  output result_t          result_o
);

  localparam int SumW = AddrW + 1;
  localparam int RndW = LenW + 1;

  logic [SumW-1:0]  span_end;
  logic [AddrW-1:0] offset;
  logic [AddrW-1:0] first_seg;
  logic [RndW-1:0]  len_round;
  logic [RndW-1:0]  seg_cnt;
  logic [SumW-1:0]  last_seg;
  logic             range_bad;
  logic [PendW-1:0] pend_dec;

  assign span_end  = {1'b0, item_i.target_address} + SumW'(item_i.length_bytes) - SumW'(1);
  assign offset    = item_i.target_address - win_start_i;
  assign first_seg = AddrW'(offset / SEGMENT_BYTES);
  assign len_round = RndW'(item_i.length_bytes) + RndW'(SEGMENT_BYTES - 1);
  assign seg_cnt   = RndW'(len_round / SEGMENT_BYTES);
  assign last_seg  = (seg_cnt == '0) ? {1'b0, first_seg}
                                     : {1'b0, first_seg} + SumW'(seg_cnt) - SumW'(1);
  assign range_bad = (item_i.target_address > win_end_i)
                  || (item_i.target_address < win_start_i)
                  || ((item_i.length_bytes != '0) && (span_end > {1'b0, win_end_i}))
                  || (last_seg >= SumW'(SegLimit));
  assign pend_dec  = state_i.pending_count - PendW'(1);

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    case (item_i.command)
      CMD_START: begin
        if (range_bad) begin
          result_o.status = 1'b1;
        end else begin
          // The last segment lies below the limit, so the count fits the pending field.
          state_o.pending_count   = PendW'(seg_cnt);
          state_o.current_segment = last_seg[SegW-1:0];
          if (seg_cnt != '0) begin
            result_o.erase_issue   = 1'b1;
            result_o.erase_segment = last_seg[SegW-1:0];
          end
        end
      end
      CMD_POLL: begin
        if ((state_i.pending_count != '0) && !item_i.flash_busy) begin
          state_o.pending_count = pend_dec;
          if (pend_dec != '0) begin
            state_o.current_segment = state_i.current_segment - SegW'(1);
            result_o.erase_issue    = 1'b1;
            result_o.erase_segment  = state_i.current_segment - SegW'(1);
          end
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
    result_o.segments_left = state_o.pending_count;
  end

endmodule

/* hdl/flash_segment_erase_sequencer.sv */
// Top level of the data-flash segment erase sequencer.
// Path: an input transfer is held in the input register, then its result in the result register.
// Throughput: one item per cycle unless the result is stalled; the state update sits between them.
// Reset: asynchronous, active low; it clears the pipeline, zeroes the pending count and current
// segment, and loads the window registers with their default addresses.
// Configuration writes are taken in every cycle and must only be made while the block is idle.
module flash_segment_erase_sequencer import fses_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write channel.
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [AddrW-1:0]   cfg_data_i,
  // Input channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic [AddrW-1:0]   target_address_i,
  input  logic [LenW-1:0]    length_bytes_i,
  input  logic               flash_busy_i,
  // Result channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               status_o,
  output logic               erase_issue_o,
  output logic [SegW-1:0]    erase_segment_o,
  output logic [PendW-1:0]   segments_left_o
);

  // Window registers, written through the configuration channel.
  logic [AddrW-1:0] win_start_q;
  logic [AddrW-1:0] win_end_q;

  // Input register stage.
  logic  in_valid_q;
  item_t item_q;

  // Sequencer state and result register.
  seq_state_t state_q;
  seq_state_t state_d;
  logic       out_valid_q;
  result_t    result_q;
  result_t    result_d;

  logic advance;
  logic in_take;

  // The configuration channel never pushes back.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q <= WinStartReset;
      win_end_q   <= WinEndReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WIN_START: win_start_q <= cfg_data_i;
        CFG_WIN_END:   win_end_q   <= cfg_data_i;
        default: begin
          win_start_q <= win_start_q;
        end
      endcase
    end
  end

  // The held item moves on into the result register whenever that register is empty or its
  // result is being taken in the same cycle. The input register frees up at the same moment,
  // so a new transfer is only refused while a held item is stuck behind a stalled result.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.command        <= command_e'(command_i);
      item_q.target_address <= target_address_i;
      item_q.length_bytes   <= length_bytes_i;
      item_q.flash_busy     <= flash_busy_i;
    end
  end

  // Window checks, segment arithmetic and the count-down all happen here, from the held item
  // and the current state, so the state is always up to date for the next item.
  fses_step u_step (
    .item_i      (item_q),
    .state_i     (state_q),
    .win_start_i (win_start_q),
    .win_end_i   (win_end_q),
    .state_o     (state_d),
    .result_o    (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = result_q.status;
  assign erase_issue_o   = result_q.erase_issue;
  assign erase_segment_o = result_q.erase_segment;
  assign segments_left_o = result_q.segments_left;

endmodule

/* hdl/fses_chk.sv */
// Port-level checker for the segment erase sequencer, bound to the top level.
module fses_chk import fses_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               status_o,
  input logic               erase_issue_o,
  input logic [SegW-1:0]    erase_segment_o,
  input logic [PendW-1:0]   segments_left_o
);

  // A rejected start never issues an erase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> !erase_issue_o)
    else $error("erase issued together with an invalid range status");

  // An issued erase always leaves at least that segment counted as pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && erase_issue_o |-> segments_left_o != '0)
    else $error("erase issued with no segments left");

  // Without an erase the segment field reads zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !erase_issue_o |-> erase_segment_o == '0)
    else $error("segment index shown without an erase");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(erase_issue_o)
      && $stable(erase_segment_o) && $stable(segments_left_o))
    else $error("stalled result changed");

endmodule

bind flash_segment_erase_sequencer fses_chk u_fses_chk (.*);
